@@ rtl/core/ira_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types and constants for the interval resource assigner.
// ----------------------------------------------------------------------------
package ira_pkg;

    localparam int MAX_RESOURCES_DEF = 64;
    localparam int TIME_W            = 32;
    localparam int RES_IDX_W         = 6;
    localparam int RES_CNT_W         = 7;

    // control for the shared compare unit
    typedef struct packed {
        logic sample_vld;
        logic sample_first;
        logic decide;
    } ira_scan_ctl_t;

endpackage

@@ rtl/core/interval_resource_assigner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_resource_assigner
// Greedy interval partitioning over a table of resource end times.
// ----------------------------------------------------------------------------
// scan: the end-time memory is scanned one entry per cycle through one
//   comparator, over the up to MAX_RESOURCES entries open in the set; no scan
//   when the set is empty or first_of_set is high
// a new item is accepted only while busy is low, once the previous one has finished
// reset: clears the open count and the sequencer; end times are not cleared
// done pulses for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
module interval_resource_assigner
    import ira_pkg::*;
#(
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 first_of_set,
    input  logic [TIME_W-1:0]    interval_start,
    input  logic [TIME_W-1:0]    interval_end,
    output logic                 done,
    output logic [RES_IDX_W-1:0] resource_index,
    output logic [RES_CNT_W-1:0] resources_in_use,
    output logic                 overflow
);

    localparam int IDX_W = $clog2(MAX_RESOURCES);
    localparam int CNT_W = $clog2(MAX_RESOURCES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [TIME_W-1:0] rd_data_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] end_reg;
    logic              done_reg, done_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              ovf_reg, ovf_next;

    logic              accept;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  best_idx;
    logic              best_below;
    ira_scan_ctl_t     scan_ctl;

    logic [TIME_W-1:0] end_mem [MAX_RESOURCES];

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    assign scan_ctl.sample_vld   = (state_reg == ST_SCAN) && rd_vld_reg;
    assign scan_ctl.sample_first = (rd_idx_reg == '0);
    assign scan_ctl.decide       = (state_reg == ST_DECIDE);

    ira_min_unit #(
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_min (
        .clk        (clk),
        .ctl        (scan_ctl),
        .sample_val (rd_data_reg),
        .sample_idx (rd_idx_reg),
        .probe_val  (start_reg),
        .best_idx   (best_idx),
        .best_below (best_below)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        rd_vld_next   = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        done_next     = 1'b0;
        idx_next      = idx_reg;
        ovf_next      = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_ptr_next = '0;
                    if (first_of_set)
                    begin
                        count_next = '0;
                        state_next = ST_DECIDE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_ptr_reg != count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_vld_next   = 1'b1;
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                end
                else
                begin
                    // last entry is being folded into the minimum this cycle
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                ovf_next   = 1'b0;
                if ((count_reg != '0) && best_below)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = best_idx;
                    idx_next = best_idx;
                end
                else if (count_reg < CNT_W'(MAX_RESOURCES))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    idx_next   = count_reg[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    idx_next = '0;
                    ovf_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_ptr_reg <= '0;
            rd_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_ptr_reg <= scan_ptr_next;
            rd_vld_reg   <= rd_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= interval_start;
            end_reg   <= interval_end;
        end
        idx_reg <= idx_next;
        ovf_reg <= ovf_next;
    end

    // end-time memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            end_mem[wr_addr] <= end_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= end_mem[scan_ptr_reg[IDX_W-1:0]];
            rd_idx_reg  <= scan_ptr_reg[IDX_W-1:0];
        end
    end

    assign done             = done_reg;
    assign resource_index   = RES_IDX_W'(idx_reg);
    assign resources_in_use = RES_CNT_W'(count_reg);
    assign overflow         = ovf_reg;

endmodule

@@ rtl/core/ira_min_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_min_unit
// Shared comparator: tracks the running minimum end time during the scan and
// then checks that minimum against the new interval's start.
// ----------------------------------------------------------------------------
module ira_min_unit
    import ira_pkg::*;
#(
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
    localparam int IDX_W = $clog2(MAX_RESOURCES)
)
(
    input  logic              clk,
    input  ira_scan_ctl_t     ctl,
    input  logic [TIME_W-1:0] sample_val,
    input  logic [IDX_W-1:0]  sample_idx,
    input  logic [TIME_W-1:0] probe_val,
    output logic [IDX_W-1:0]  best_idx,
    output logic              best_below
);

    logic [TIME_W-1:0] best_val_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TIME_W-1:0] op_a;
    logic [TIME_W-1:0] op_b;
    logic              lt;

    // one comparator, operands switched between scan and decision
    assign op_a = ctl.decide ? best_val_reg : sample_val;
    assign op_b = ctl.decide ? probe_val    : best_val_reg;
    assign lt   = (op_a < op_b);

    // strict compare keeps the lowest index on ties
    always_ff @(posedge clk)
    begin
        if (ctl.sample_vld && !ctl.decide && (ctl.sample_first || lt))
        begin
            best_val_reg <= sample_val;
            best_idx_reg <= sample_idx;
        end
    end

    assign best_idx   = best_idx_reg;
    assign best_below = lt;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interval_resource_assigner: a short table of
// directed intervals, then sorted interval sets with random content, sets
// that run out of resources, and unsorted noise. Each result is checked field
// by field against the table's want values or an in-bench greedy assignment model.
// ----------------------------------------------------------------------------
module tb;
    import ira_pkg::*;

    localparam int          MAX_RES      = MAX_RESOURCES_DEF;
    localparam int          RANDOM_ITEMS = 1850;
    localparam int          DRAIN_CYCLES = MAX_RES + 16;
    localparam longint      CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic [RES_IDX_W-1:0] index;
        logic [RES_CNT_W-1:0] in_use;
        logic                 ovf;
    } assignment_t;

    typedef struct {
        logic              first;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
        logic              has_want;
        assignment_t       want;
    } interval_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 first_of_set;
    logic [TIME_W-1:0]    interval_start;
    logic [TIME_W-1:0]    interval_end;
    logic                 done;
    logic [RES_IDX_W-1:0] resource_index;
    logic [RES_CNT_W-1:0] resources_in_use;
    logic                 overflow;

    // greedy model state
    logic [TIME_W-1:0] end_time_model [MAX_RES];
    int unsigned       open_model;

    assignment_t       pending_assignments [$];
    interval_row_t     interval_table [$];
    int unsigned       mismatch_count;
    int unsigned       idle_pct;
    longint unsigned   cycle_count;
    assignment_t       oldest_assignment;
    assignment_t       seen_assignment;

    interval_resource_assigner #(
        .MAX_RESOURCES(MAX_RES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .first_of_set     (first_of_set),
        .interval_start   (interval_start),
        .interval_end     (interval_end),
        .done             (done),
        .resource_index   (resource_index),
        .resources_in_use (resources_in_use),
        .overflow         (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
    endfunction

    // smallest end time wins, lowest index on ties; reuse only if strictly earlier
    task automatic assign_interval(input logic first, input logic [TIME_W-1:0] t_start,
                                   input logic [TIME_W-1:0] t_end,
                                   output assignment_t res);
        int unsigned best;
        logic        reuse;
        begin
            best  = 0;
            reuse = 1'b0;
            res   = '0;
            if (first)
                open_model = 0;
            if (open_model > 0)
            begin
                for (int k = 1; k < open_model; k++)
                    if (end_time_model[k] < end_time_model[best])
                        best = k;
                if (end_time_model[best] < t_start)
                    reuse = 1'b1;
            end
            if (reuse)
            begin
                res.index            = RES_IDX_W'(best);
                end_time_model[best] = t_end;
            end
            else if (open_model < MAX_RES)
            begin
                res.index                  = RES_IDX_W'(open_model);
                end_time_model[open_model] = t_end;
                open_model++;
            end
            else
                res.ovf = 1'b1;
            res.in_use = RES_CNT_W'(open_model);
        end
    endtask

    task automatic report_mismatch(input string what, input assignment_t want,
                                   input assignment_t got);
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch (%s): want idx=%0d used=%0d ovf=%0b, got idx=%0d used=%0d ovf=%0b",
                         what, want.index, want.in_use, want.ovf,
                         got.index, got.in_use, got.ovf);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_assignment = '{resource_index, resources_in_use, overflow};
            if (pending_assignments.size() == 0)
                report_mismatch("unexpected result", '0, seen_assignment);
            else
            begin
                oldest_assignment = pending_assignments.pop_front();
                if (seen_assignment.index !== oldest_assignment.index)
                    report_mismatch("resource_index", oldest_assignment, seen_assignment);
                else if (seen_assignment.in_use !== oldest_assignment.in_use)
                    report_mismatch("resources_in_use", oldest_assignment, seen_assignment);
                else if (seen_assignment.ovf !== oldest_assignment.ovf)
                    report_mismatch("overflow", oldest_assignment, seen_assignment);
            end
        end
    end

    task automatic add_row(input logic first, input logic [TIME_W-1:0] t_start,
                           input logic [TIME_W-1:0] t_end, input logic has_want,
                           input int idx, input int used, input logic ovf);
        interval_row_t row;
        begin
            row.first    = first;
            row.t_start  = t_start;
            row.t_end    = t_end;
            row.has_want = has_want;
            row.want     = '{RES_IDX_W'(idx), RES_CNT_W'(used), ovf};
            interval_table.push_back(row);
        end
    endtask

    // called and returns at a falling edge; start stays high until told otherwise
    task automatic send_interval(input logic first, input logic [TIME_W-1:0] t_start,
                                 input logic [TIME_W-1:0] t_end, input logic has_want,
                                 input assignment_t want);
        assignment_t predicted;
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            start          <= 1'b1;
            first_of_set   <= first;
            interval_start <= t_start;
            interval_end   <= t_end;
            do
                @(posedge clk);
            while (busy);
            assign_interval(first, t_start, t_end, predicted);
            pending_assignments.push_back(has_want ? want : predicted);
            @(negedge clk);
        end
    endtask

    task automatic drain_pending();
        begin
            start <= 1'b0;
            @(negedge clk);
            while (pending_assignments.size() != 0)
                @(negedge clk);
        end
    endtask

    initial
    begin
        int unsigned       sent;
        int unsigned       phase;
        int unsigned       last_phase;
        int unsigned       kind;
        int unsigned       set_len;
        int unsigned       step_max;
        int unsigned       dur_max;
        int unsigned       dur_min;
        int unsigned       inc;
        int unsigned       phase_idle [4];
        logic [TIME_W-1:0] t_s;
        logic [TIME_W-1:0] t_e;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] prev_dur;
        logic              first;

        phase_idle     = '{0, 50, 0, 17};
        rst_n          = 1'b0;
        start          = 1'b0;
        first_of_set   = 1'b0;
        interval_start = '0;
        interval_end   = '0;
        idle_pct       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        open_model     = 0;
        sent           = 0;
        last_phase     = 0;

        // opening, reuse of the earliest end, end equal to start opens a new one
        add_row(1'b1, 32'd10, 32'd20, 1'b1, 0, 1, 1'b0);
        add_row(1'b0, 32'd15, 32'd30, 1'b1, 1, 2, 1'b0);
        add_row(1'b0, 32'd21, 32'd25, 1'b1, 0, 2, 1'b0);
        add_row(1'b0, 32'd25, 32'd40, 1'b1, 2, 3, 1'b0);
        add_row(1'b0, 32'd31, 32'd35, 1'b1, 0, 3, 1'b0);
        // tie on smallest end goes to the lowest index
        add_row(1'b1, 32'd0, 32'd5, 1'b1, 0, 1, 1'b0);
        add_row(1'b0, 32'd1, 32'd5, 1'b1, 1, 2, 1'b0);
        add_row(1'b0, 32'd6, 32'd9, 1'b1, 0, 2, 1'b0);
        // time extremes
        add_row(1'b1, 32'd0, 32'd0, 1'b1, 0, 1, 1'b0);
        add_row(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1, 1, 2, 1'b0);
        add_row(1'b0, 32'd1, 32'd7, 1'b1, 0, 2, 1'b0);
        add_row(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, 2, 1'b0);
        add_row(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1, 2, 3, 1'b0);
        // end before start, then starts out of order
        add_row(1'b1, 32'd100, 32'd50, 1'b1, 0, 1, 1'b0);
        add_row(1'b0, 32'd60, 32'd70, 1'b1, 0, 1, 1'b0);
        add_row(1'b0, 32'd10, 32'd20, 1'b1, 1, 2, 1'b0);
        add_row(1'b0, 32'd5, 32'd5, 1'b1, 2, 3, 1'b0);
        add_row(1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1, 0, 1, 1'b0);
        add_row(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 0, 0, 1'b0);
        add_row(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 0, 0, 1'b0);
        add_row(1'b0, 32'h5555_5556, 32'h0000_0001, 1'b0, 0, 0, 1'b0);
        add_row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < interval_table.size(); i++)
            send_interval(interval_table[i].first, interval_table[i].t_start,
                          interval_table[i].t_end, interval_table[i].has_want,
                          interval_table[i].want);
        drain_pending();

        while (sent < RANDOM_ITEMS)
        begin
            kind    = $urandom_range(0, 99);
            dur_min = 0;
            if (kind < 70)
            begin
                // well-formed set: ascending starts, ties ordered by end
                set_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 16);
                step_max = 1 << $urandom_range(0, 20);
                dur_max  = 1 << $urandom_range(0, 22);
                t_s      = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
            end
            else if (kind < 78)
            begin
                // everything overlaps, so the set runs out of resources
                set_len  = MAX_RES + $urandom_range(1, 8);
                step_max = 1;
                dur_min  = 1000;
                dur_max  = $urandom;
                t_s      = $urandom_range(0, 32'h7FFF_FFFF);
            end
            else
            begin
                set_len  = $urandom_range(1, 10);
                step_max = 0;
                dur_max  = 0;
                t_s      = '0;
            end

            prev_dur = '0;
            for (int j = 0; j < set_len; j++)
            begin
                if (kind >= 78)
                begin
                    // noise: unsorted, any end, set boundaries at random
                    first = ($urandom_range(0, 3) == 0);
                    t_s   = $urandom;
                    t_e   = $urandom;
                end
                else
                begin
                    first = (j == 0);
                    inc   = (j == 0) ? 0 : $urandom_range(0, step_max);
                    t_s   = sat_add(t_s, inc);
                    dur   = sat_add(dur_min, $urandom_range(0, dur_max));
                    if (j > 0 && inc == 0 && dur < prev_dur)
                        dur = prev_dur;
                    prev_dur = dur;
                    t_e      = sat_add(t_s, dur);
                end

                phase = (sent * 4) / RANDOM_ITEMS;
                if (phase > 3)
                    phase = 3;
                if (phase != last_phase)
                begin
                    // let everything in flight come back before the new phase
                    drain_pending();
                    @(negedge clk);
                    last_phase = phase;
                end
                idle_pct = phase_idle[phase];
                send_interval(first, t_s, t_e, 1'b0, '0);
                sent++;
            end
        end

        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ira_pkg.sv
rtl/core/ira_min_unit.sv
rtl/core/interval_resource_assigner.sv
tb/sv/tb.sv
